// ----- rtl/row_softmax_macros.svh -----
// assertion macros for the row softmax block
`ifndef ROW_SOFTMAX_MACROS_SVH
`define ROW_SOFTMAX_MACROS_SVH

// implication checked every clock after reset
`define RSM_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("row_softmax check failed");

// next-cycle implication
`define RSM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("row_softmax check failed");

`endif

// ----- rtl/rsm_pkg.sv -----
// ---------------------------------------------------------------------------
// rsm_pkg
// shared types and constants of the row softmax block
// ---------------------------------------------------------------------------
`default_nettype none

package rsm_pkg;
    typedef logic [31:0] t_factor;

    localparam int LOGIT_W = 16;
    localparam int EXP_W   = 16;
    localparam int SUM_W   = 22;
    localparam int PROB_W  = 17;
    localparam int POS_W   = 6;

    // round(exp(-2^k) * 2^32), k = -12 .. 3
    function automatic t_factor exp_factor(input logic [3:0] idx);
        t_factor f;
        case (idx)
            4'd0:    f = 32'd4293918848;
            4'd1:    f = 32'd4292870656;
            4'd2:    f = 32'd4290775039;
            4'd3:    f = 32'd4286586875;
            4'd4:    f = 32'd4278222805;
            4'd5:    f = 32'd4261543595;
            4'd6:    f = 32'd4228380000;
            4'd7:    f = 32'd4162825044;
            4'd8:    f = 32'd4034748382;
            4'd9:    f = 32'd3790295335;
            4'd10:   f = 32'd3344923893;
            4'd11:   f = 32'd2605029347;
            4'd12:   f = 32'd1580030169;
            4'd13:   f = 32'd581260616;
            4'd14:   f = 32'd78665070;
            default: f = 32'd1440801;
        endcase
        return f;
    endfunction
endpackage

`default_nettype wire

// ----- rtl/row_softmax.sv -----
// ---------------------------------------------------------------------------
// row_softmax
// max-subtracted softmax over one row of fixed-point logits
// ---------------------------------------------------------------------------
// Elements are taken one per cycle while busy is low; each is written into
// the row memory and the running peak is updated. The element marked row_end
// closes the row and raises busy. Pass one reads each stored element
// (registered memory read), forms exp(x - peak) by a shift-and-multiply over
// the 16 bits of the difference (one 33x32 multiply per cycle) and writes the
// result back into the exp memory while summing. Pass two reads each exp
// value and divides it by the sum with a restoring divider that starts from
// e/2, since the upper quotient bits are always zero, and forms the 17
// quotient bits one per cycle. Results come out on o_valid for one cycle
// each and cannot be stalled. Elements past ROW_DEPTH are dropped and flag
// o_row_overflow on every result.
// ---------------------------------------------------------------------------
`default_nettype none

module row_softmax
    import rsm_pkg::*;
#(
    parameter int ROW_DEPTH = 64,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [LOGIT_W-1:0]  i_logit,
    input  wire logic                       i_row_end,
    output logic                            o_valid,
    output logic [PROB_W-1:0]               o_probability,
    output logic [POS_W-1:0]                o_position,
    output logic                            o_final_of_row,
    output logic                            o_row_overflow
);
    localparam int AW  = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int CW  = $clog2(ROW_DEPTH + 1);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_XRD   = 3'd1;
    localparam logic [2:0] S_EXP   = 3'd2;
    localparam logic [2:0] S_DRD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    logic [LOGIT_W-1:0] row_mem [ROW_DEPTH];
    logic [EXP_W-1:0]   exp_mem [ROW_DEPTH];

    logic [2:0]                r_state, n_state;
    logic [CW-1:0]             r_count;
    logic signed [LOGIT_W-1:0] r_peak;
    logic                      r_drop;
    logic [AW-1:0]             r_idx;
    logic [4:0]                r_bit;
    logic [32:0]               r_acc;
    logic [15:0]               r_d;
    logic                      r_zero;
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W:0]            r_rem;
    logic [EXP_W-1:0]          r_num;
    logic [PROB_W-1:0]         r_quo;
    logic [LOGIT_W-1:0]        r_rd_x;
    logic [EXP_W-1:0]          r_rd_e;

    logic              accept;
    logic              wr_en;
    logic [AW-1:0]     rd_addr;
    logic              exp_wr;
    logic [EXP_W-1:0]  exp_val;
    logic [63:0]       prod;
    logic [3:0]        fidx;
    logic [4:0]        bit_j;
    logic [SUM_W:0]    rem_sh;
    logic [CW-1:0]     idx_ext;
    logic              last_idx;

    assign busy     = (r_state != S_LOAD);
    assign accept   = start && !busy;
    assign wr_en    = accept && (r_count != CW'(ROW_DEPTH));
    assign idx_ext  = CW'(r_idx);
    assign last_idx = (idx_ext + CW'(1)) == r_count;

    // bit j of the difference maps to table entry j - FRAC_BITS + 12
    assign bit_j = r_bit - 5'd1;
    assign fidx  = 4'(bit_j + 5'd12 - 5'(FRAC_BITS));
    assign prod  = 64'(r_acc) * 64'(exp_factor(fidx));

    always_comb begin
        if (r_zero) begin
            exp_val = '0;
        end else if (r_acc[32]) begin
            exp_val = '1;
        end else begin
            exp_val = r_acc[31:16];
        end
    end

    assign exp_wr = (r_state == S_EXP) && (r_bit == 5'd17);
    assign rem_sh = {r_rem[SUM_W-1:0], r_num[EXP_W-1]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            row_mem[r_count[AW-1:0]] <= i_logit;
        end
        r_rd_x <= row_mem[rd_addr];
        if (exp_wr) begin
            exp_mem[r_idx] <= exp_val;
        end
        r_rd_e <= exp_mem[rd_addr];
    end

    assign rd_addr = r_idx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (accept && i_row_end) n_state = S_XRD;
            S_XRD:  n_state = S_EXP;
            S_EXP:  if (r_bit == 5'd17) n_state = last_idx ? S_DRD : S_XRD;
            S_DRD:  n_state = S_DIV;
            S_DIV:  if (r_bit == 5'd18) n_state = last_idx ? S_LOAD : S_DRD;
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_peak  <= {1'b1, {(LOGIT_W-1){1'b0}}};
            r_drop  <= 1'b0;
            r_idx   <= '0;
            r_bit   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    r_idx <= '0;
                    r_sum <= '0;
                    if (accept) begin
                        if (wr_en) begin
                            r_count <= r_count + CW'(1);
                            if (i_logit > r_peak) r_peak <= i_logit;
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                S_XRD: begin
                    r_bit <= '0;
                end
                S_EXP: begin
                    // step 0 latches d, steps 1..16 take one bit each
                    if (r_bit != 5'd17) begin
                        r_bit <= r_bit + 5'd1;
                    end else begin
                        r_sum <= r_sum + SUM_W'(exp_val);
                        r_idx <= last_idx ? '0 : r_idx + AW'(1);
                    end
                end
                S_DRD: begin
                    r_bit <= '0;
                end
                S_DIV: begin
                    if (r_bit != 5'd18) begin
                        r_bit <= r_bit + 5'd1;
                    end else begin
                        o_valid        <= 1'b1;
                        o_probability  <= r_quo;
                        o_position     <= POS_W'(r_idx);
                        o_final_of_row <= last_idx;
                        o_row_overflow <= r_drop;
                        r_idx          <= last_idx ? '0 : r_idx + AW'(1);
                        r_bit          <= '0;
                        if (last_idx) begin
                            r_count <= '0;
                            r_peak  <= {1'b1, {(LOGIT_W-1){1'b0}}};
                            r_drop  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // exponent multiply loop and divider datapath: payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXP) begin
            if (r_bit == 5'd0) begin
                r_d    <= 16'(r_peak - signed'(r_rd_x));
                r_acc  <= 33'h1_0000_0000;
                r_zero <= 1'b0;
            end else if (r_bit != 5'd17) begin
                r_d <= r_d >> 1;
                if (r_d[0]) begin
                    if (bit_j >= 5'(FRAC_BITS + 4)) begin
                        r_zero <= 1'b1;
                    end else if (bit_j + 5'd12 >= 5'(FRAC_BITS)) begin
                        r_acc <= {1'b0, prod[63:32]};
                    end
                end
            end
        end
        if (r_state == S_DIV) begin
            if (r_bit == 5'd0) begin
                // dividend is e << 16; the quotient never exceeds 17 bits
                r_num <= {r_rd_e[0], {(EXP_W-1){1'b0}}};
                r_rem <= {{(SUM_W-EXP_W+2){1'b0}}, r_rd_e[EXP_W-1:1]};
                r_quo <= '0;
            end else if (r_bit != 5'd18) begin
                r_num <= r_num << 1;
                if (rem_sh >= {1'b0, r_sum}) begin
                    r_rem <= rem_sh - {1'b0, r_sum};
                    r_quo <= {r_quo[PROB_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[PROB_W-2:0], 1'b0};
                end
            end
        end
    end
endmodule

`default_nettype wire

// ----- rtl/rsm_checker.sv -----
// ---------------------------------------------------------------------------
// rsm_checker
// port-level checks of the row softmax block
// ---------------------------------------------------------------------------
`default_nettype none
`include "row_softmax_macros.svh"

module rsm_checker
    import rsm_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              busy,
    input wire logic              o_valid,
    input wire logic [PROB_W-1:0] o_probability,
    input wire logic              o_final_of_row
);
    `RSM_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy || o_final_of_row)
    `RSM_ASSERT_IMP(a_prob_range, i_clk, i_rst_n, o_valid, o_probability <= 17'd65536)
    `RSM_ASSERT_IMP(a_final_idle, i_clk, i_rst_n, o_valid && o_final_of_row, !busy)
    `RSM_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_valid, !o_valid)
endmodule

bind row_softmax rsm_checker u_rsm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .busy(busy),
    .o_valid(o_valid), .o_probability(o_probability),
    .o_final_of_row(o_final_of_row)
);

`default_nettype wire
